### hdl/assert_macros.svh
// assertion macros used by the checker file rlqt_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RLQT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RLQT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rlqt_pkg.sv
// types and constants of the rssi link quality tracker
// used by every module of the block and by its checker
package rlqt_pkg;

	localparam logic [2:0] MODE_PERF     = 3'd0;
	localparam logic [2:0] MODE_NORMAL   = 3'd1;
	localparam logic [2:0] MODE_RANGE    = 3'd2;
	localparam logic [2:0] MODE_WEAK     = 3'd3;
	localparam logic [2:0] MODE_RECOVERY = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PERF_EXIT_BELOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_UP_ABOVE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DOWN_BELOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_UP_ABOVE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_DOWN_BELOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEAK_UP_ABOVE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WEAK_DOWN_BELOW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_UP_ABOVE = 3'd7;

	// fixed thresholds used on link-up to pick the starting mode
	localparam logic signed [7:0] INIT_PERF_MIN   = -8'sd55;
	localparam logic signed [7:0] INIT_NORMAL_MIN = -8'sd68;
	localparam logic signed [7:0] INIT_RANGE_MIN  = -8'sd76;
	localparam logic signed [7:0] INIT_WEAK_MIN   = -8'sd84;

	// reported level while the link is down
	localparam logic signed [7:0] DOWN_DBM = -8'sd100;

	typedef struct packed {
		logic signed [7:0] perf_exit_below;
		logic signed [7:0] normal_up_above;
		logic signed [7:0] normal_down_below;
		logic signed [7:0] range_up_above;
		logic signed [7:0] range_down_below;
		logic signed [7:0] weak_up_above;
		logic signed [7:0] weak_down_below;
		logic signed [7:0] recovery_up_above;
	} thresh_t;

	localparam thresh_t THRESH_RESET = '{
		perf_exit_below:   -8'sd60,
		normal_up_above:   -8'sd53,
		normal_down_below: -8'sd71,
		range_up_above:    -8'sd64,
		range_down_below:  -8'sd79,
		weak_up_above:     -8'sd72,
		weak_down_below:   -8'sd86,
		recovery_up_above: -8'sd80
	};

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [7:0] rssi;
		logic              changed;
	} result_t;

endpackage

### hdl/rlqt_update.sv
// next-state and result logic for one rssi sample: smoothing, rounding, mode step
// depends on rlqt_pkg
module rlqt_update #(
	parameter int FRAC_BITS = 8
) (
	input  logic                         conn,
	input  logic signed [7:0]            raw,
	input  logic                         link_up,
	input  logic signed [FRAC_BITS+7:0]  smooth,
	input  logic [2:0]                   mode,
	input  rlqt_pkg::thresh_t            thr,
	output logic signed [FRAC_BITS+7:0]  smooth_nxt,
	output logic [2:0]                   mode_nxt,
	output rlqt_pkg::result_t            res
);

	localparam int SW = FRAC_BITS + 8;
	localparam int AW = SW + 2;
	localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

	function automatic logic [2:0] init_mode(input logic signed [7:0] r);
		logic [2:0] m;
		if (r >= rlqt_pkg::INIT_PERF_MIN) m = rlqt_pkg::MODE_PERF;
		else if (r >= rlqt_pkg::INIT_NORMAL_MIN) m = rlqt_pkg::MODE_NORMAL;
		else if (r >= rlqt_pkg::INIT_RANGE_MIN) m = rlqt_pkg::MODE_RANGE;
		else if (r >= rlqt_pkg::INIT_WEAK_MIN) m = rlqt_pkg::MODE_WEAK;
		else m = rlqt_pkg::MODE_RECOVERY;
		return m;
	endfunction

	// "above" is checked before "below" in every mode that has both
	function automatic logic [2:0] step_mode(input logic [2:0] cur,
			input logic signed [7:0] r, input rlqt_pkg::thresh_t t);
		logic [2:0] m;
		m = cur;
		case (cur)
			rlqt_pkg::MODE_PERF: begin
				if (r < t.perf_exit_below) m = rlqt_pkg::MODE_NORMAL;
			end
			rlqt_pkg::MODE_NORMAL: begin
				if (r > t.normal_up_above) m = rlqt_pkg::MODE_PERF;
				else if (r < t.normal_down_below) m = rlqt_pkg::MODE_RANGE;
			end
			rlqt_pkg::MODE_RANGE: begin
				if (r > t.range_up_above) m = rlqt_pkg::MODE_NORMAL;
				else if (r < t.range_down_below) m = rlqt_pkg::MODE_WEAK;
			end
			rlqt_pkg::MODE_WEAK: begin
				if (r > t.weak_up_above) m = rlqt_pkg::MODE_RANGE;
				else if (r < t.weak_down_below) m = rlqt_pkg::MODE_RECOVERY;
			end
			rlqt_pkg::MODE_RECOVERY: begin
				if (r > t.recovery_up_above) m = rlqt_pkg::MODE_RANGE;
			end
			default: m = init_mode(r);
		endcase
		return m;
	endfunction

	logic                 rise;
	logic                 fall;
	logic signed [SW-1:0] raw_ext;
	logic signed [SW-1:0] down_ext;
	logic signed [SW-1:0] base;
	logic [2:0]           base_mode;
	logic signed [AW-1:0] acc;
	logic signed [SW-1:0] upd;
	logic                 upd_neg;
	logic [SW-1:0]        mag;
	logic [SW-1:0]        mag_rnd;
	logic [7:0]           rnd;
	logic signed [7:0]    shown;

	assign rise     = conn & ~link_up;
	assign fall     = ~conn & link_up;
	assign raw_ext  = $signed({raw, {FRAC_BITS{1'b0}}});
	assign down_ext = $signed({rlqt_pkg::DOWN_DBM, {FRAC_BITS{1'b0}}});

	assign base      = rise ? raw_ext : smooth;
	assign base_mode = rise ? init_mode(raw) : mode;

	// 3*old + raw*2^F, then floor divide by 4 as an arithmetic shift
	assign acc = (AW'(base) <<< 1) + AW'(base) + AW'(raw_ext);
	assign upd = acc[AW-1:2];

	// round half away from zero on the magnitude
	assign upd_neg = upd[SW-1];
	assign mag     = upd_neg ? (~upd + SW'(1)) : upd;
	assign mag_rnd = mag + HALF;
	assign rnd     = mag_rnd[SW-1:FRAC_BITS];
	assign shown   = upd_neg ? $signed(-rnd) : $signed(rnd);

	always_comb begin
		if (conn) begin
			smooth_nxt = upd;
			mode_nxt   = step_mode(base_mode, shown, thr);
			res.rssi   = shown;
		end else begin
			smooth_nxt = fall ? down_ext : smooth;
			mode_nxt   = fall ? rlqt_pkg::MODE_RECOVERY : mode;
			res.rssi   = rlqt_pkg::DOWN_DBM;
		end
		res.mode    = mode_nxt;
		res.changed = (mode_nxt != mode);
	end

endmodule

### hdl/rssi_link_quality_tracker.sv
// top level of the rssi link quality tracker: input register, state, result register
// depends on rlqt_pkg and rlqt_update
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall   link_connected, raw_rssi
//  out      source     out_valid / out_stall link_mode, smoothed_rssi, mode_changed
//  cfg      sink       cfg_we               cfg_index, cfg_wdata
//
// one beat per cycle sustained while the result is not blocked; a beat goes from the
// input register to the result register, with smoothing and mode update done
// combinationally from the state registers; reset presets the state and thresholds
// and clears both valid flags; no clearing pass; in_stall is high only while the input
// register holds a beat and the result register holds a beat that out_stall is blocking
module rssi_link_quality_tracker #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  link_connected,
	input  logic signed [7:0]                     raw_rssi,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [2:0]                            link_mode,
	output logic signed [7:0]                     smoothed_rssi,
	output logic                                  mode_changed,
	input  logic                                  cfg_we,
	input  logic [rlqt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [7:0]                            cfg_wdata
);

	localparam int SW = FRAC_BITS + 8;

	logic                  valid_s1;
	logic                  conn_s1;
	logic signed [7:0]     raw_s1;
	logic                  out_valid_q;
	rlqt_pkg::result_t     res_q;
	logic                  link_up_q;
	logic signed [SW-1:0]  smooth_q;
	logic [2:0]            mode_q;
	rlqt_pkg::thresh_t     thr_q;

	logic                  adv;
	logic                  in_take;
	logic signed [SW-1:0]  smooth_nxt;
	logic [2:0]            mode_nxt;
	rlqt_pkg::result_t     res_nxt;

	// the stage-one beat moves on unless the result register is held
	assign adv      = valid_s1 & ~(out_valid_q & out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign in_take  = in_valid & ~in_stall;

	rlqt_update #(
		.FRAC_BITS(FRAC_BITS)
	) u_update (
		.conn       (conn_s1),
		.raw        (raw_s1),
		.link_up    (link_up_q),
		.smooth     (smooth_q),
		.mode       (mode_q),
		.thr        (thr_q),
		.smooth_nxt (smooth_nxt),
		.mode_nxt   (mode_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			conn_s1 <= link_connected;
			raw_s1  <= raw_rssi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			link_up_q   <= 1'b0;
			smooth_q    <= $signed({rlqt_pkg::DOWN_DBM, {FRAC_BITS{1'b0}}});
			mode_q      <= rlqt_pkg::MODE_RECOVERY;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			link_up_q   <= conn_s1;
			smooth_q    <= smooth_nxt;
			mode_q      <= mode_nxt;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rlqt_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rlqt_pkg::REG_PERF_EXIT_BELOW:   thr_q.perf_exit_below   <= cfg_wdata;
				rlqt_pkg::REG_NORMAL_UP_ABOVE:   thr_q.normal_up_above   <= cfg_wdata;
				rlqt_pkg::REG_NORMAL_DOWN_BELOW: thr_q.normal_down_below <= cfg_wdata;
				rlqt_pkg::REG_RANGE_UP_ABOVE:    thr_q.range_up_above    <= cfg_wdata;
				rlqt_pkg::REG_RANGE_DOWN_BELOW:  thr_q.range_down_below  <= cfg_wdata;
				rlqt_pkg::REG_WEAK_UP_ABOVE:     thr_q.weak_up_above     <= cfg_wdata;
				rlqt_pkg::REG_WEAK_DOWN_BELOW:   thr_q.weak_down_below   <= cfg_wdata;
				rlqt_pkg::REG_RECOVERY_UP_ABOVE: thr_q.recovery_up_above <= cfg_wdata;
				default: thr_q <= thr_q;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign link_mode     = res_q.mode;
	assign smoothed_rssi = res_q.rssi;
	assign mode_changed  = res_q.changed;

endmodule

### hdl/rlqt_checker.sv
// port-level checks on the rssi link quality tracker, bound to the top level
// depends on rlqt_pkg and assert_macros.svh
`include "assert_macros.svh"

module rlqt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             link_connected,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [2:0]                       link_mode,
	input logic signed [7:0]                smoothed_rssi,
	input logic                             mode_changed
);

	logic in_beat;
	assign in_beat = in_valid & ~in_stall;

	// a held result beat keeps its payload
	`RLQT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(link_mode) && $stable(smoothed_rssi) && $stable(mode_changed), "result beat changed while stalled")

	// input side only backs up behind a blocked result
	`RLQT_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a blocked result")

	// with the output free a taken beat passes the input register into the result register
	`RLQT_ASSERT_NXT(a_latency, clk, arst_n, in_beat ##1 !out_stall, out_valid, "result beat missing after two cycles")

	// a link-down sample reports recovery at the down level
	`RLQT_ASSERT_NXT(a_link_down, clk, arst_n, (in_beat && !link_connected) ##1 !out_stall, out_valid && smoothed_rssi == rlqt_pkg::DOWN_DBM && link_mode == rlqt_pkg::MODE_RECOVERY, "link-down beat not reported as recovery")

endmodule

bind rssi_link_quality_tracker rlqt_checker u_rlqt_checker (.*);
